[hdl/tla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_pkg
// shared types, constants and codes of the one-row tile layout block
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam int MAX_WINDOWS_DEF = 16;

  localparam int PRIO_W  = 8;
  localparam int DIM_W   = 13;
  localparam int TAG_W   = 8;
  localparam int RATIO_W = 16;
  localparam int SCALE_W = 24;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  // shared divider widths
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 14;

  localparam logic [DIM_W-1:0]   CANVAS_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0]   CANVAS_HEIGHT_RST = 13'd1080;
  localparam logic [RATIO_W-1:0] RATIO_RST         = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_RATIO_FEW     = 2'd2,
    REG_RATIO_MULTI   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_CLR, S_SCAN, S_SCAN_TAIL, S_FETCH, S_LATCH, S_DECIDE,
    S_MUL1, S_MUL2, S_MW_START, S_MW_WAIT, S_RW_START, S_RW_WAIT,
    S_SLOT_MAIN, S_SLOT_ONE, S_SLOT_CHILD, S_F_PROD, S_F_SEL, S_F_MUL,
    S_DW_START, S_DW_WAIT, S_DH_START, S_DH_WAIT, S_SC_START, S_SC_WAIT,
    S_F_FIN, S_EMIT, S_EMIT_FAIL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SCAN_CLR, OP_SCAN_STEP, OP_FETCH, OP_LATCH,
    OP_MUL1, OP_MUL2, OP_MW_START, OP_MW_CAP, OP_RW_START, OP_RW_CAP,
    OP_SLOT_MAIN, OP_SLOT_ONE, OP_SLOT_CHILD, OP_F_PROD, OP_F_SEL, OP_F_MUL,
    OP_DW_START, OP_DW_CAP, OP_DH_START, OP_DH_CAP, OP_SC_START, OP_SC_CAP,
    OP_F_FIN, OP_EMIT, OP_EMIT_FAIL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic begin_layout;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
    logic k_zero;
    logic prio_bad;
    logic single;
    logic fit_ok;
    logic last_item;
  } sts_t;

endpackage

[hdl/tla_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tla_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tla_pkg::DIV_NW-1:0] num,
  input  logic [tla_pkg::DIV_DW-1:0] den,
  output logic [tla_pkg::DIV_NW-1:0] quo,
  output logic [tla_pkg::DIV_DW-1:0] rem,
  output logic                       done
);

  localparam int NW  = tla_pkg::DIV_NW;
  localparam int DW  = tla_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem, quo[NW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !start && active && (cnt == CNT_W'(1));
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NW);
        rem    <= '0;
        quo    <= num;
        dvs    <= den;
      end else if (active) begin
        if (ge) begin
          rem <= DW'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[DW-1:0];
        end
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

[hdl/tla_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_ctrl
// layout sequencer: load, sort scan, main width, per-slot fit and emit
// ----------------------------------------------------------------------------
module tla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last_window,
  input  tla_pkg::sts_t sts,
  output tla_pkg::cmd_t cmd,
  output logic          busy
);

  tla_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd.op           = tla_pkg::OP_NONE;
    cmd.load         = 1'b0;
    cmd.begin_layout = 1'b0;
    busy             = 1'b1;
    case (state)
      tla_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && last_window) begin
          cmd.begin_layout = 1'b1;
          state_next       = tla_pkg::S_SCAN_CLR;
        end
      end
      tla_pkg::S_SCAN_CLR: begin
        cmd.op     = tla_pkg::OP_SCAN_CLR;
        state_next = tla_pkg::S_SCAN;
      end
      tla_pkg::S_SCAN: begin
        cmd.op = tla_pkg::OP_SCAN_STEP;
        if (sts.scan_last) state_next = tla_pkg::S_SCAN_TAIL;
      end
      tla_pkg::S_SCAN_TAIL: state_next = tla_pkg::S_FETCH;
      tla_pkg::S_FETCH: begin
        cmd.op     = tla_pkg::OP_FETCH;
        state_next = tla_pkg::S_LATCH;
      end
      tla_pkg::S_LATCH: begin
        cmd.op     = tla_pkg::OP_LATCH;
        state_next = tla_pkg::S_DECIDE;
      end
      tla_pkg::S_DECIDE: begin
        if (!sts.k_zero)       state_next = tla_pkg::S_SLOT_CHILD;
        else if (sts.prio_bad) state_next = tla_pkg::S_EMIT_FAIL;
        else if (sts.single)   state_next = tla_pkg::S_SLOT_ONE;
        else                   state_next = tla_pkg::S_MUL1;
      end
      tla_pkg::S_MUL1: begin
        cmd.op     = tla_pkg::OP_MUL1;
        state_next = tla_pkg::S_MUL2;
      end
      tla_pkg::S_MUL2: begin
        cmd.op     = tla_pkg::OP_MUL2;
        state_next = tla_pkg::S_MW_START;
      end
      tla_pkg::S_MW_START: begin
        cmd.op     = tla_pkg::OP_MW_START;
        state_next = tla_pkg::S_MW_WAIT;
      end
      tla_pkg::S_MW_WAIT: begin
        cmd.op = tla_pkg::OP_MW_CAP;
        if (sts.div_done) state_next = tla_pkg::S_RW_START;
      end
      tla_pkg::S_RW_START: begin
        cmd.op     = tla_pkg::OP_RW_START;
        state_next = tla_pkg::S_RW_WAIT;
      end
      tla_pkg::S_RW_WAIT: begin
        cmd.op = tla_pkg::OP_RW_CAP;
        if (sts.div_done) state_next = tla_pkg::S_SLOT_MAIN;
      end
      tla_pkg::S_SLOT_MAIN: begin
        cmd.op     = tla_pkg::OP_SLOT_MAIN;
        state_next = tla_pkg::S_F_PROD;
      end
      tla_pkg::S_SLOT_ONE: begin
        cmd.op     = tla_pkg::OP_SLOT_ONE;
        state_next = tla_pkg::S_F_PROD;
      end
      tla_pkg::S_SLOT_CHILD: begin
        cmd.op     = tla_pkg::OP_SLOT_CHILD;
        state_next = tla_pkg::S_F_PROD;
      end
      tla_pkg::S_F_PROD: begin
        cmd.op     = tla_pkg::OP_F_PROD;
        state_next = tla_pkg::S_F_SEL;
      end
      tla_pkg::S_F_SEL: begin
        cmd.op     = tla_pkg::OP_F_SEL;
        state_next = sts.fit_ok ? tla_pkg::S_F_MUL : tla_pkg::S_EMIT;
      end
      tla_pkg::S_F_MUL: begin
        cmd.op     = tla_pkg::OP_F_MUL;
        state_next = tla_pkg::S_DW_START;
      end
      tla_pkg::S_DW_START: begin
        cmd.op     = tla_pkg::OP_DW_START;
        state_next = tla_pkg::S_DW_WAIT;
      end
      tla_pkg::S_DW_WAIT: begin
        cmd.op = tla_pkg::OP_DW_CAP;
        if (sts.div_done) state_next = tla_pkg::S_DH_START;
      end
      tla_pkg::S_DH_START: begin
        cmd.op     = tla_pkg::OP_DH_START;
        state_next = tla_pkg::S_DH_WAIT;
      end
      tla_pkg::S_DH_WAIT: begin
        cmd.op = tla_pkg::OP_DH_CAP;
        if (sts.div_done) state_next = tla_pkg::S_SC_START;
      end
      tla_pkg::S_SC_START: begin
        cmd.op     = tla_pkg::OP_SC_START;
        state_next = tla_pkg::S_SC_WAIT;
      end
      tla_pkg::S_SC_WAIT: begin
        cmd.op = tla_pkg::OP_SC_CAP;
        if (sts.div_done) state_next = tla_pkg::S_F_FIN;
      end
      tla_pkg::S_F_FIN: begin
        cmd.op     = tla_pkg::OP_F_FIN;
        state_next = tla_pkg::S_EMIT;
      end
      tla_pkg::S_EMIT: begin
        cmd.op     = tla_pkg::OP_EMIT;
        state_next = sts.last_item ? tla_pkg::S_IDLE : tla_pkg::S_SCAN_CLR;
      end
      tla_pkg::S_EMIT_FAIL: begin
        cmd.op     = tla_pkg::OP_EMIT_FAIL;
        state_next = tla_pkg::S_IDLE;
      end
      default: state_next = tla_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/tla_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_dp
// window store, sort scan, slot geometry and fit arithmetic
// ----------------------------------------------------------------------------
module tla_dp #(
  parameter int MAX_WINDOWS = tla_pkg::MAX_WINDOWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tla_pkg::cmd_t                 cmd,
  output tla_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]     cfg_data,
  input  logic [tla_pkg::PRIO_W-1:0]    priority_req,
  input  logic [tla_pkg::DIM_W-1:0]     source_width,
  input  logic [tla_pkg::DIM_W-1:0]     source_height,
  input  logic [tla_pkg::TAG_W-1:0]     window_tag,
  output logic                          strobe,
  output logic                          layout_ok,
  output logic [tla_pkg::TAG_W-1:0]     tag_out,
  output logic [tla_pkg::DIM_W-1:0]     slot_left,
  output logic [tla_pkg::DIM_W-1:0]     slot_width,
  output logic [tla_pkg::DIM_W-1:0]     slot_height,
  output logic [tla_pkg::DIM_W-1:0]     draw_left,
  output logic [tla_pkg::DIM_W-1:0]     draw_top,
  output logic [tla_pkg::DIM_W-1:0]     draw_width,
  output logic [tla_pkg::DIM_W-1:0]     draw_height,
  output logic [tla_pkg::SCALE_W-1:0]   fit_scale,
  output logic                          last_result
);

  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int KEY_W = tla_pkg::PRIO_W + IDX_W;
  localparam int DIM_W = tla_pkg::DIM_W;
  localparam int NW    = tla_pkg::DIV_NW;
  localparam int DW    = tla_pkg::DIV_DW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOWS);

  // configuration
  logic [DIM_W-1:0]            cw, ch;
  logic [tla_pkg::RATIO_W-1:0] ratio_few, ratio_multi;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw          <= tla_pkg::CANVAS_WIDTH_RST;
      ch          <= tla_pkg::CANVAS_HEIGHT_RST;
      ratio_few   <= tla_pkg::RATIO_RST;
      ratio_multi <= tla_pkg::RATIO_RST;
    end else if (cfg_we) begin
      case (tla_pkg::cfg_reg_t'(cfg_index))
        tla_pkg::REG_CANVAS_WIDTH:  cw          <= cfg_data[DIM_W-1:0];
        tla_pkg::REG_CANVAS_HEIGHT: ch          <= cfg_data[DIM_W-1:0];
        tla_pkg::REG_RATIO_FEW:     ratio_few   <= cfg_data;
        tla_pkg::REG_RATIO_MULTI:   ratio_multi <= cfg_data;
        default: ;
      endcase
    end
  end

  // window store
  tla_pkg::entry_t store [MAX_WINDOWS];
  tla_pkg::entry_t rdata;
  tla_pkg::entry_t cur;
  logic [CNT_W-1:0] count, j, k;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] best_key, last_key, cand;
  logic             best_valid, key_valid, pend;
  logic [IDX_W-1:0] pend_idx;

  assign rd_addr = (cmd.op == tla_pkg::OP_FETCH) ? best_key[IDX_W-1:0] : j[IDX_W-1:0];
  assign cand    = {rdata.prio, pend_idx};

  always_ff @(posedge clk) begin
    rdata <= store[rd_addr];
    if (cmd.load && count < MAX_CNT) begin
      store[count[IDX_W-1:0]] <= '{prio: priority_req, w: source_width,
                                   h: source_height, tag: window_tag};
    end
  end

  // geometry and fit registers
  logic [28:0]      mul1;
  logic [41:0]      mul2;
  logic [42:0]      area_sum;
  logic [26:0]      area;
  logic [DIM_W-1:0] divden;
  logic [CNT_W-1:0] children, rem_cnt, kk;
  logic [DIM_W-1:0] mainw, base, x, sx, sw, sh;
  logic [25:0]      p1, p2, m1, m2;
  logic [DIM_W-1:0] fnum, fden, dw, dh, dx, dy;
  logic [tla_pkg::SCALE_W-1:0] sc;
  logic             fit_ok;
  logic [DIM_W-1:0] mw_clamp, rest, child_w, dw_c, dh_c;
  logic [DIM_W+1:0] lim;

  // shared divider
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [DW-1:0] div_den, div_r;

  assign children = count - 1'b1;
  assign kk       = k - 1'b1;
  assign area_sum = {1'b0, mul2} + 43'd65535;
  assign area     = area_sum[42:16];
  assign divden   = (ch == '0) ? DIM_W'(1) : ch;
  assign rest     = cw - mainw;
  assign child_w  = base + DIM_W'(kk < rem_cnt);
  assign fit_ok   = (cur.w != '0) && (cur.h != '0) && (sw != '0) && (sh != '0);
  assign lim      = {2'b00, cw} - (DIM_W+2)'(children);

  always_comb begin
    mw_clamp = (div_q > NW'(cw)) ? cw : div_q[DIM_W-1:0];
    if (mw_clamp == '0) mw_clamp = DIM_W'(1);
    // children may not fit next to the main slot
    if ($signed({2'b00, mw_clamp}) > $signed(lim)) begin
      mw_clamp = lim[DIM_W+1] ? '0 : lim[DIM_W-1:0];
    end
  end

  always_comb begin
    dw_c = (div_q == '0) ? DIM_W'(1) : ((div_q > NW'(sw)) ? sw : div_q[DIM_W-1:0]);
    dh_c = (div_q == '0) ? DIM_W'(1) : ((div_q > NW'(sh)) ? sh : div_q[DIM_W-1:0]);
  end

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      tla_pkg::OP_MW_START: begin
        div_num = NW'(area) + NW'(divden) - NW'(1);
        div_den = DW'(divden);
      end
      tla_pkg::OP_RW_START: begin
        div_num = NW'(rest);
        div_den = DW'(children);
      end
      tla_pkg::OP_DW_START: begin
        div_num = NW'({m1, 1'b0}) + NW'(fden);
        div_den = DW'({fden, 1'b0});
      end
      tla_pkg::OP_DH_START: begin
        div_num = NW'({m2, 1'b0}) + NW'(fden);
        div_den = DW'({fden, 1'b0});
      end
      tla_pkg::OP_SC_START: begin
        div_num = NW'({fnum, 17'b0}) + NW'(fden);
        div_den = DW'({fden, 1'b0});
      end
      default: div_start = 1'b0;
    endcase
  end

  tla_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .rem   (div_r),
    .done  (div_done)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      j          <= '0;
      k          <= '0;
      pend       <= 1'b0;
      best_valid <= 1'b0;
      key_valid  <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= (cmd.op == tla_pkg::OP_EMIT) || (cmd.op == tla_pkg::OP_EMIT_FAIL);
      pend   <= (cmd.op == tla_pkg::OP_SCAN_STEP);
      if (cmd.load && count < MAX_CNT) count <= count + 1'b1;
      if (cmd.begin_layout) begin
        k         <= '0;
        key_valid <= 1'b0;
      end
      // next window in stable priority order: smallest key above the last one
      if (pend && (!key_valid || cand > last_key) && (!best_valid || cand < best_key)) begin
        best_valid <= 1'b1;
        best_key   <= cand;
      end
      case (cmd.op)
        tla_pkg::OP_SCAN_CLR: begin
          j          <= '0;
          best_valid <= 1'b0;
        end
        tla_pkg::OP_SCAN_STEP: begin
          pend_idx <= j[IDX_W-1:0];
          j        <= j + 1'b1;
        end
        tla_pkg::OP_LATCH: begin
          key_valid <= 1'b1;
          last_key  <= best_key;
        end
        tla_pkg::OP_EMIT: begin
          k <= k + 1'b1;
          if (sts.last_item) count <= '0;
        end
        tla_pkg::OP_EMIT_FAIL: begin
          count <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      tla_pkg::OP_LATCH: cur  <= rdata;
      tla_pkg::OP_MUL1:  mul1 <= ((children > CNT_W'(2)) ? ratio_multi : ratio_few) * cw;
      tla_pkg::OP_MUL2:  mul2 <= mul1 * ch;
      tla_pkg::OP_MW_CAP: if (div_done) mainw <= mw_clamp;
      tla_pkg::OP_RW_CAP: if (div_done) begin
        base    <= div_q[DIM_W-1:0];
        rem_cnt <= CNT_W'(div_r);
      end
      tla_pkg::OP_SLOT_MAIN: begin
        sx <= '0;
        sw <= mainw;
        sh <= ch;
        x  <= mainw;
      end
      tla_pkg::OP_SLOT_ONE: begin
        sx <= '0;
        sw <= cw;
        sh <= ch;
      end
      tla_pkg::OP_SLOT_CHILD: begin
        sx <= x;
        sw <= child_w;
        sh <= ch;
        x  <= x + child_w;
      end
      tla_pkg::OP_F_PROD: begin
        p1 <= sw * cur.h;
        p2 <= sh * cur.w;
      end
      tla_pkg::OP_F_SEL: begin
        if (p1 <= p2) begin
          fnum <= sw;
          fden <= cur.w;
        end else begin
          fnum <= sh;
          fden <= cur.h;
        end
        if (!fit_ok) begin
          dx <= '0;
          dy <= '0;
          dw <= '0;
          dh <= '0;
          sc <= '0;
        end
      end
      tla_pkg::OP_F_MUL: begin
        m1 <= cur.w * fnum;
        m2 <= cur.h * fnum;
      end
      tla_pkg::OP_DW_CAP: if (div_done) dw <= dw_c;
      tla_pkg::OP_DH_CAP: if (div_done) dh <= dh_c;
      tla_pkg::OP_SC_CAP: if (div_done) begin
        sc <= (div_q > NW'(tla_pkg::SCALE_MAX)) ? tla_pkg::SCALE_MAX
                                                 : div_q[tla_pkg::SCALE_W-1:0];
      end
      tla_pkg::OP_F_FIN: begin
        dx <= sx + ((sw - dw) >> 1);
        dy <= (sh - dh) >> 1;
      end
      tla_pkg::OP_EMIT: begin
        layout_ok   <= 1'b1;
        tag_out     <= cur.tag;
        slot_left   <= sx;
        slot_width  <= sw;
        slot_height <= sh;
        draw_left   <= dx;
        draw_top    <= dy;
        draw_width  <= dw;
        draw_height <= dh;
        fit_scale   <= sc;
        last_result <= sts.last_item;
      end
      tla_pkg::OP_EMIT_FAIL: begin
        layout_ok   <= 1'b0;
        tag_out     <= '0;
        slot_left   <= '0;
        slot_width  <= '0;
        slot_height <= '0;
        draw_left   <= '0;
        draw_top    <= '0;
        draw_width  <= '0;
        draw_height <= '0;
        fit_scale   <= '0;
        last_result <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.scan_last = (j == count - 1'b1);
  assign sts.div_done  = div_done;
  assign sts.k_zero    = (k == '0);
  assign sts.prio_bad  = (cur.prio != '0);
  assign sts.single    = (count == CNT_W'(1));
  assign sts.fit_ok    = fit_ok;
  assign sts.last_item = (k == count - 1'b1);

endmodule

[hdl/tile_layout_aspect_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_layout_aspect_fit
// one-row window layout with stable priority order and aspect-preserving fit
// ----------------------------------------------------------------------------
// Windows load one item per cycle while busy is low; the item with
// last_window set starts the layout and busy stays high until the last
// result is issued. Results appear one per strobe cycle and cannot be held
// off, so take them as they come. Per result the block first finds the
// next window in priority order (one store read per cycle), then does
// slot set-up and products, three passes of the shared serial divider
// for the fit, and the finish and emit; an invalid fit skips the divider
// passes. The main window of a multi-window layout adds the area
// multiply and two more divider passes for the main and child widths.
module tile_layout_aspect_fit #(
  parameter int MAX_WINDOWS = tla_pkg::MAX_WINDOWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]     cfg_data,
  input  logic [tla_pkg::PRIO_W-1:0]    priority_req,
  input  logic [tla_pkg::DIM_W-1:0]     source_width,
  input  logic [tla_pkg::DIM_W-1:0]     source_height,
  input  logic [tla_pkg::TAG_W-1:0]     window_tag,
  input  logic                          last_window,
  output logic                          strobe,
  output logic                          layout_ok,
  output logic [tla_pkg::TAG_W-1:0]     tag_out,
  output logic [tla_pkg::DIM_W-1:0]     slot_left,
  output logic [tla_pkg::DIM_W-1:0]     slot_width,
  output logic [tla_pkg::DIM_W-1:0]     slot_height,
  output logic [tla_pkg::DIM_W-1:0]     draw_left,
  output logic [tla_pkg::DIM_W-1:0]     draw_top,
  output logic [tla_pkg::DIM_W-1:0]     draw_width,
  output logic [tla_pkg::DIM_W-1:0]     draw_height,
  output logic [tla_pkg::SCALE_W-1:0]   fit_scale,
  output logic                          last_result
);

  tla_pkg::cmd_t cmd;
  tla_pkg::sts_t sts;

  tla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_window (last_window),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  tla_dp #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .priority_req  (priority_req),
    .source_width  (source_width),
    .source_height (source_height),
    .window_tag    (window_tag),
    .strobe        (strobe),
    .layout_ok     (layout_ok),
    .tag_out       (tag_out),
    .slot_left     (slot_left),
    .slot_width    (slot_width),
    .slot_height   (slot_height),
    .draw_left     (draw_left),
    .draw_top      (draw_top),
    .draw_width    (draw_width),
    .draw_height   (draw_height),
    .fit_scale     (fit_scale),
    .last_result   (last_result)
  );

endmodule
